// ===== sv/mcf_pkg.sv =====
package mcf_pkg;

	localparam int MAX_TAPS    = 64;
	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 16;

	localparam int LINE_DEPTH = MAX_TAPS - 1;
	localparam int FRAC_BITS  = SAMPLE_BITS - 1;
	localparam int TAP_W      = $clog2(MAX_TAPS);
	localparam int CHA_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CH_W      = 3;
	localparam int TI_W      = 6;
	localparam int TC_W      = 7;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 7;
	localparam int REG_IDX_W = 1;

	localparam logic [1:0] OP_FILTER = 2'd0;
	localparam logic [1:0] OP_TAP    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MODE      = 1'b1;

	localparam logic [MODE_W-1:0] MODE_REAL      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CPLX_TAPS = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [CH_W-1:0] channel;
		logic [TI_W-1:0] tap_index;
		smp_t            value_re;
		smp_t            value_im;
	} sample_t;

	typedef struct packed {
		smp_t            out_re;
		smp_t            out_im;
		logic [CH_W-1:0] out_channel;
		logic            saturated;
	} result_t;

	typedef struct packed {
		logic            en;
		logic [TI_W-1:0] idx;
		smp_t            re;
		smp_t            im;
	} tap_wr_t;

	typedef struct packed {
		logic             issue;
		logic             first;
		logic [CH_W-1:0]  ch;
		logic [TAP_W-1:0] k;
	} rd_req_t;

	typedef struct packed {
		smp_t t_re;
		smp_t t_im;
		logic t_ok;
		smp_t x_re;
		smp_t x_im;
		logic x_ok;
	} rd_data_t;

	typedef struct packed {
		logic            en;
		logic [CH_W-1:0] ch;
		smp_t            re;
		smp_t            im;
	} push_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

endpackage

// ===== sv/mcf_store.sv =====
module mcf_store (
	input  logic               clk,
	input  logic               arst_n,
	input  mcf_pkg::tap_wr_t   tap_wr,
	input  logic               clear,
	input  mcf_pkg::push_t     push,
	input  mcf_pkg::rd_req_t   req,
	output mcf_pkg::rd_data_t  rd
);

	localparam int SB   = mcf_pkg::SAMPLE_BITS;
	localparam int TW   = mcf_pkg::TAP_W;
	localparam int CW   = mcf_pkg::CHA_W;
	localparam int AW   = CW + TW;
	localparam int IX_W = ((TW > mcf_pkg::TI_W) ? TW : mcf_pkg::TI_W) + 1;
	localparam logic [TW-1:0] LAST_SLOT = TW'(mcf_pkg::LINE_DEPTH - 1);
	localparam logic [TW-1:0] FULL      = TW'(mcf_pkg::LINE_DEPTH);

	logic [2*SB-1:0] tap_mem [mcf_pkg::MAX_TAPS];
	logic [2*SB-1:0] dl_mem [1 << AW];

	logic [mcf_pkg::MAX_TAPS-1:0] tap_vld_q;
	logic [TW-1:0] head_q [mcf_pkg::CHANNELS];
	logic [TW-1:0] fill_q [mcf_pkg::CHANNELS];
	logic [TW-1:0] slot_q;

	logic [2*SB-1:0] tap_rd_s1;
	logic [2*SB-1:0] dl_rd_s1;
	logic            tap_ok_s1;
	logic            dl_ok_s1;

	logic [IX_W-1:0] ti_x;
	logic            tap_hit;
	logic [TW-1:0]   tap_addr;
	logic [CW-1:0]   rd_ch;
	logic [CW-1:0]   push_ch;
	logic [TW-1:0]   push_slot;
	logic [TW-1:0]   age;

	always_comb begin
		ti_x      = IX_W'(tap_wr.idx);
		tap_hit   = tap_wr.en && (ti_x < IX_W'(mcf_pkg::MAX_TAPS));
		tap_addr  = TW'(ti_x);
		rd_ch     = CW'(req.ch);
		push_ch   = CW'(push.ch);
		push_slot = (head_q[push_ch] == LAST_SLOT) ? '0 : head_q[push_ch] + 1'b1;
		age       = req.k - 1'b1;
	end

	// tap table
	always_ff @(posedge clk) begin
		if (tap_hit) begin
			tap_mem[tap_addr] <= {tap_wr.re, tap_wr.im};
		end
	end

	always_ff @(posedge clk) begin
		tap_rd_s1 <= tap_mem[req.k];
	end

	// delay lines
	always_ff @(posedge clk) begin
		if (push.en) begin
			dl_mem[{push_ch, push_slot}] <= {push.re, push.im};
		end
	end

	always_ff @(posedge clk) begin
		dl_rd_s1 <= dl_mem[{rd_ch, slot_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_q <= '0;
		end else if (tap_hit) begin
			tap_vld_q[tap_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_ok_s1 <= 1'b0;
			dl_ok_s1  <= 1'b0;
			slot_q    <= '0;
		end else begin
			tap_ok_s1 <= tap_vld_q[req.k];
			// entries older than the fill count were never written since the last clear
			dl_ok_s1  <= !req.first && (age < fill_q[rd_ch]);
			if (req.issue) begin
				if (req.first) begin
					slot_q <= head_q[rd_ch];
				end else begin
					slot_q <= (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcf_pkg::CHANNELS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (clear) begin
			for (int i = 0; i < mcf_pkg::CHANNELS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (push.en) begin
			head_q[push_ch] <= push_slot;
			if (fill_q[push_ch] != FULL) begin
				fill_q[push_ch] <= fill_q[push_ch] + 1'b1;
			end
		end
	end

	always_comb begin
		rd.t_re = tap_rd_s1[2*SB-1:SB];
		rd.t_im = tap_rd_s1[SB-1:0];
		rd.t_ok = tap_ok_s1;
		rd.x_re = dl_rd_s1[2*SB-1:SB];
		rd.x_im = dl_rd_s1[SB-1:0];
		rd.x_ok = dl_ok_s1;
	end

endmodule

// ===== sv/mcf_mac.sv =====
module mcf_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  mcf_pkg::mac_ctl_t  ctl_s1,
	input  logic               use_xi,
	input  logic               use_ti,
	input  mcf_pkg::smp_t      smp_re,
	input  mcf_pkg::smp_t      smp_im,
	input  mcf_pkg::rd_data_t  rd,
	output logic               done,
	output mcf_pkg::smp_t      y_re,
	output mcf_pkg::smp_t      y_im,
	output logic               clip
);

	localparam int SB     = mcf_pkg::SAMPLE_BITS;
	localparam int FB     = mcf_pkg::FRAC_BITS;
	localparam int PROD_W = 2 * SB;
	localparam int ACC_R  = 2 * SB + mcf_pkg::TAP_W + 2;
	localparam int ACC_W  = (ACC_R < 64) ? ACC_R : 64;
	localparam int Q_W    = ACC_W - FB;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		mcf_pkg::smp_t val;
		logic          clip;
	} fin_t;

	localparam acc_t ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
	localparam acc_t ROUND_HALF = acc_t'(1) <<< (FB - 1);
	localparam mcf_pkg::smp_t SMP_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam mcf_pkg::smp_t SMP_MIN = {1'b1, {(SB-1){1'b0}}};

	function automatic acc_t sat_add(acc_t a, acc_t b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return acc_t'(s[ACC_W-1:0]);
	endfunction

	// round half up, drop the fraction, clip to the sample range
	function automatic fin_t round_sat(acc_t acc);
		acc_t           v;
		logic [Q_W-1:0] q;
		fin_t           r;
		v = sat_add(acc, ROUND_HALF);
		q = v[ACC_W-1:FB];
		if ((&q[Q_W-1:SB-1]) || !(|q[Q_W-1:SB-1])) begin
			r.val  = q[SB-1:0];
			r.clip = 1'b0;
		end else begin
			r.val  = q[Q_W-1] ? SMP_MIN : SMP_MAX;
			r.clip = 1'b1;
		end
		return r;
	endfunction

	mcf_pkg::smp_t     xr, xi, tr, ti;
	prod_t             p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	mcf_pkg::mac_ctl_t ctl_s2;
	acc_t              acc_re_q, acc_im_q;
	acc_t              base_re, base_im;
	acc_t              acc_re_d, acc_im_d;
	logic              done_q;
	fin_t              fin_re, fin_im;

	// operands: tap 0 is the new sample; unwritten entries, unused imag parts are 0
	always_comb begin
		if (ctl_s1.first) begin
			xr = smp_re;
			xi = smp_im;
		end else if (rd.x_ok) begin
			xr = rd.x_re;
			xi = rd.x_im;
		end else begin
			xr = '0;
			xi = '0;
		end
		if (!use_xi) begin
			xi = '0;
		end
		tr = rd.t_ok ? rd.t_re : '0;
		ti = (rd.t_ok && use_ti) ? rd.t_im : '0;
	end

	always_ff @(posedge clk) begin
		p_rr_s2 <= tr * xr;
		p_ii_s2 <= ti * xi;
		p_ri_s2 <= tr * xi;
		p_ir_s2 <= ti * xr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.vld && ctl_s2.last;
		end
	end

	always_comb begin
		base_re  = ctl_s2.first ? '0 : acc_re_q;
		base_im  = ctl_s2.first ? '0 : acc_im_q;
		acc_re_d = sat_add(sat_add(base_re, acc_t'(p_rr_s2)), -acc_t'(p_ii_s2));
		acc_im_d = sat_add(sat_add(base_im, acc_t'(p_ri_s2)), acc_t'(p_ir_s2));
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_re_q <= acc_re_d;
			acc_im_q <= acc_im_d;
		end
	end

	always_comb begin
		fin_re = round_sat(acc_re_q);
		fin_im = round_sat(acc_im_q);
		done   = done_q;
		y_re   = fin_re.val;
		y_im   = use_xi ? fin_im.val : '0;
		clip   = fin_re.clip || (use_xi && fin_im.clip);
	end

endmodule

// ===== sv/multichannel_fir_filter.sv =====
// Multichannel direct-form FIR filter, Q1.15 complex samples.
// Input channel: sample_valid / sample_stall / sample. An item is taken when
// valid is high and stall is low. op selects filter, tap write or clear.
// Result channel: result_valid / result_stall / result, one item per filter
// item; tap writes, clears, unknown ops and bad channels give nothing.
// Configuration: cfg_we, cfg_index (0 tap count, 1 mode), cfg_data; write only
// while the filter is idle.
// Timing: a filter item goes from acceptance through the memory read,
// multiply, accumulate and rounding to result valid; the next item can be
// taken in that same cycle. The shared complex multiply-accumulate handles
// one tap per cycle behind the registered tap and delay-line memory reads.
// Tap writes and clears are taken while idle and leave the block idle.
// Reset: taps read as zero until written, delay lines start empty, tap count
// is 1 and mode is real. No clearing pass is needed; the filter is ready at once.
// Stall: a finished result waits in the output register while the next item is
// filtered; if it is still not taken when that item finishes, the block holds
// and keeps sample_stall high until it is.
module multichannel_fir_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  mcf_pkg::sample_t                    sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output mcf_pkg::result_t                    result,
	input  logic                                cfg_we,
	input  logic [mcf_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [mcf_pkg::CFG_W-1:0]           cfg_data
);

	localparam int TW    = mcf_pkg::TAP_W;
	localparam int TCX_W = (mcf_pkg::TC_W > TW + 1) ? mcf_pkg::TC_W : TW + 1;

	logic [mcf_pkg::TC_W-1:0]   tap_count_q;
	logic [mcf_pkg::MODE_W-1:0] mode_q;
	logic                       use_xi, use_ti;

	mcf_pkg::state_t            state_q, state_d;
	logic [TW-1:0]              k_q, last_k_q, last_k_d;
	logic [TCX_W-1:0]           tc_x;
	logic [mcf_pkg::CH_W-1:0]   ch_q;
	mcf_pkg::smp_t              smp_re_q, smp_im_q;
	mcf_pkg::mac_ctl_t          ctl_s1;
	mcf_pkg::result_t           res_q;
	logic                       res_valid_q;

	logic                       accept, start, ch_ok, issue, out_free, load_res, push_en;
	logic                       mac_done, mac_clip;
	mcf_pkg::smp_t              y_re, y_im;
	mcf_pkg::tap_wr_t           tap_wr;
	mcf_pkg::push_t             push;
	mcf_pkg::rd_req_t           req;
	mcf_pkg::rd_data_t          rd;
	logic                       clear;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= mcf_pkg::TC_W'(1);
			mode_q      <= mcf_pkg::MODE_REAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcf_pkg::REG_TAP_COUNT: tap_count_q <= cfg_data;
				mcf_pkg::REG_MODE:      mode_q      <= cfg_data[mcf_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		use_xi = mode_q != mcf_pkg::MODE_REAL;
		use_ti = mode_q >= mcf_pkg::MODE_CPLX_TAPS;
		// zero taps act as one, too many clamp to the table depth
		tc_x = TCX_W'(tap_count_q);
		if (tc_x == '0) begin
			last_k_d = '0;
		end else if (tc_x > TCX_W'(mcf_pkg::MAX_TAPS)) begin
			last_k_d = TW'(mcf_pkg::MAX_TAPS - 1);
		end else begin
			last_k_d = TW'(tc_x - 1'b1);
		end
	end

	always_comb begin
		accept   = sample_valid && !sample_stall;
		ch_ok    = 32'(sample.channel) < 32'(mcf_pkg::CHANNELS);
		start    = accept && (sample.op == mcf_pkg::OP_FILTER) && ch_ok;
		out_free = !res_valid_q || !result_stall;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcf_pkg::ST_IDLE: begin
				if (start) begin
					state_d = mcf_pkg::ST_RUN;
				end
			end
			mcf_pkg::ST_RUN: begin
				if (k_q == last_k_q) begin
					state_d = mcf_pkg::ST_DRAIN;
				end
			end
			mcf_pkg::ST_DRAIN: begin
				if (mac_done) begin
					state_d = out_free ? mcf_pkg::ST_IDLE : mcf_pkg::ST_HOLD;
				end
			end
			mcf_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = mcf_pkg::ST_IDLE;
				end
			end
			default: state_d = mcf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		sample_stall = 1'b1;
		issue        = 1'b0;
		push_en      = 1'b0;
		load_res     = 1'b0;
		unique case (state_q)
			mcf_pkg::ST_IDLE:  sample_stall = 1'b0;
			mcf_pkg::ST_RUN:   issue = 1'b1;
			mcf_pkg::ST_DRAIN: begin
				push_en  = mac_done;
				load_res = mac_done && out_free;
			end
			mcf_pkg::ST_HOLD:  load_res = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mcf_pkg::ST_IDLE;
			k_q      <= '0;
			last_k_q <= '0;
			ctl_s1   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				k_q      <= '0;
				last_k_q <= last_k_d;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
			ctl_s1.vld   <= issue;
			ctl_s1.first <= k_q == '0;
			ctl_s1.last  <= k_q == last_k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ch_q     <= sample.channel;
			smp_re_q <= sample.value_re;
			smp_im_q <= sample.value_im;
		end
	end

	always_comb begin
		tap_wr.en  = accept && (sample.op == mcf_pkg::OP_TAP);
		tap_wr.idx = sample.tap_index;
		tap_wr.re  = sample.value_re;
		tap_wr.im  = sample.value_im;
		clear      = accept && (sample.op == mcf_pkg::OP_CLEAR);
		push.en    = push_en;
		push.ch    = ch_q;
		push.re    = smp_re_q;
		push.im    = smp_im_q;
		req.issue  = issue;
		req.first  = k_q == '0;
		req.ch     = ch_q;
		req.k      = k_q;
	end

	mcf_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.tap_wr (tap_wr),
		.clear  (clear),
		.push   (push),
		.req    (req),
		.rd     (rd)
	);

	mcf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.use_xi (use_xi),
		.use_ti (use_ti),
		.smp_re (smp_re_q),
		.smp_im (smp_im_q),
		.rd     (rd),
		.done   (mac_done),
		.y_re   (y_re),
		.y_im   (y_im),
		.clip   (mac_clip)
	);

	// output register: hold the finished item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.out_re      <= y_re;
			res_q.out_im      <= y_im;
			res_q.out_channel <= ch_q;
			res_q.saturated   <= mac_clip;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == mcf_pkg::ST_DRAIN)
		else $error("accumulator finished outside drain");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mcf_pkg::ST_RUN |-> k_q <= last_k_q)
		else $error("tap counter ran past the tap count");

	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mcf_pkg::ST_IDLE |-> !ctl_s1.vld && !mac_done)
		else $error("MAC pipeline busy while idle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(state_q == mcf_pkg::ST_DRAIN || state_q == mcf_pkg::ST_HOLD))
		else $error("result appeared outside item completion");

endmodule

// ===== bench/multichannel_fir_filter_tb.sv =====
`timescale 1ns / 1ps

module multichannel_fir_filter_tb;

	localparam logic [1:0]                 OP_NONE           = 2'd3;
	localparam logic [mcf_pkg::MODE_W-1:0] MODE_CPLX_SAMPLES = 2'd1;
	localparam logic [mcf_pkg::MODE_W-1:0] MODE_RESERVED     = 2'd3;

	localparam longint S_MAX = (longint'(1) << mcf_pkg::FRAC_BITS) - 1;
	localparam longint S_MIN = -S_MAX - 1;

	// long enough for a filter item with 64 taps to finish, with margin
	localparam int DRAIN_CYCLES   = 80;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_stall;
	mcf_pkg::sample_t              sample       = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	mcf_pkg::result_t              result;
	logic                          cfg_we       = 1'b0;
	logic [mcf_pkg::REG_IDX_W-1:0] cfg_index    = '0;
	logic [mcf_pkg::CFG_W-1:0]     cfg_data     = '0;

	// filter state as predicted
	mcf_pkg::smp_t             coef_re [mcf_pkg::MAX_TAPS];
	mcf_pkg::smp_t             coef_im [mcf_pkg::MAX_TAPS];
	mcf_pkg::smp_t             hist_re [mcf_pkg::CHANNELS][mcf_pkg::LINE_DEPTH];
	mcf_pkg::smp_t             hist_im [mcf_pkg::CHANNELS][mcf_pkg::LINE_DEPTH];
	int                        ntaps;
	logic [mcf_pkg::MODE_W-1:0] cur_mode;

	mcf_pkg::result_t pending_results[$];
	int      mismatches   = 0;
	int      send_pct     = 0;
	int      stall_pct    = 0;
	int      holds_asked  = 0;
	int      holds_taken  = 0;
	int      hold_left    = 0;
	int      quiet_cycles = 0;

	multichannel_fir_filter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic mcf_pkg::smp_t round_clip(input longint acc, inout bit clip);
		longint q;
		q = (acc + (longint'(1) << (mcf_pkg::FRAC_BITS - 1))) >>> mcf_pkg::FRAC_BITS;
		if (q > S_MAX) begin
			clip = 1'b1;
			q = S_MAX;
		end else if (q < S_MIN) begin
			clip = 1'b1;
			q = S_MIN;
		end
		return mcf_pkg::smp_t'(q);
	endfunction

	function automatic void clear_history();
		foreach (hist_re[c, i]) begin
			hist_re[c][i] = '0;
			hist_im[c][i] = '0;
		end
	endfunction

	function automatic void reset_filter_state();
		foreach (coef_re[k]) begin
			coef_re[k] = '0;
			coef_im[k] = '0;
		end
		clear_history();
		ntaps    = 1;
		cur_mode = mcf_pkg::MODE_REAL;
	endfunction

	function automatic void predict_item(input mcf_pkg::sample_t s);
		int               n;
		bit               use_xi, use_ti, clip;
		longint           acc_re, acc_im, xr, xi, tr, ti;
		mcf_pkg::result_t r;
		case (s.op)
			mcf_pkg::OP_TAP: begin
				coef_re[s.tap_index] = s.value_re;
				coef_im[s.tap_index] = s.value_im;
			end
			mcf_pkg::OP_CLEAR: clear_history();
			mcf_pkg::OP_FILTER: begin
				n      = (ntaps == 0) ? 1 :
					((ntaps > mcf_pkg::MAX_TAPS) ? mcf_pkg::MAX_TAPS : ntaps);
				use_xi = cur_mode != mcf_pkg::MODE_REAL;
				use_ti = cur_mode >= mcf_pkg::MODE_CPLX_TAPS;
				acc_re = 0;
				acc_im = 0;
				clip   = 1'b0;
				for (int k = 0; k < n; k++) begin
					if (k == 0) begin
						xr = s.value_re;
						xi = s.value_im;
					end else begin
						xr = hist_re[s.channel][k-1];
						xi = hist_im[s.channel][k-1];
					end
					if (!use_xi)
						xi = 0;
					tr = coef_re[k];
					ti = use_ti ? longint'(coef_im[k]) : 0;
					acc_re += tr * xr - ti * xi;
					acc_im += tr * xi + ti * xr;
				end
				r.out_re      = round_clip(acc_re, clip);
				r.out_im      = use_xi ? round_clip(acc_im, clip) : '0;
				r.out_channel = s.channel;
				r.saturated   = clip;
				pending_results.push_back(r);
				// newest sample goes to the front of the history
				for (int i = mcf_pkg::LINE_DEPTH - 1; i > 0; i--) begin
					hist_re[s.channel][i] = hist_re[s.channel][i-1];
					hist_im[s.channel][i] = hist_im[s.channel][i-1];
				end
				hist_re[s.channel][0] = s.value_re;
				hist_im[s.channel][0] = s.value_im;
			end
			default: ;
		endcase
	endfunction

	function automatic mcf_pkg::smp_t pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return '1;
			default: return mcf_pkg::smp_t'($urandom);
		endcase
	endfunction

	function automatic mcf_pkg::sample_t random_item(input int ch_max);
		mcf_pkg::sample_t s;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 88)
			s.op = mcf_pkg::OP_FILTER;
		else if (r < 96)
			s.op = mcf_pkg::OP_TAP;
		else if (r < 97)
			s.op = mcf_pkg::OP_CLEAR;
		else
			s.op = OP_NONE;
		s.channel   = mcf_pkg::CH_W'($urandom_range(0, ch_max));
		s.tap_index = mcf_pkg::TI_W'($urandom_range(0, mcf_pkg::MAX_TAPS - 1));
		s.value_re  = pick_value();
		s.value_im  = pick_value();
		return s;
	endfunction

	function automatic mcf_pkg::sample_t make_item(input logic [1:0] op, input int ch,
		input int ti, input int re, input int im);
		mcf_pkg::sample_t s;
		s.op        = op;
		s.channel   = mcf_pkg::CH_W'(ch);
		s.tap_index = mcf_pkg::TI_W'(ti);
		s.value_re  = mcf_pkg::smp_t'(re);
		s.value_im  = mcf_pkg::smp_t'(im);
		return s;
	endfunction

	task automatic send_item(input mcf_pkg::sample_t item);
		while ($urandom_range(0, 99) < send_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= item;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		predict_item(item);
	endtask

	// drop valid, wait for every result, then let any trailing item finish
	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int taps, input logic [mcf_pkg::MODE_W-1:0] md);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= mcf_pkg::REG_TAP_COUNT;
		cfg_data  <= mcf_pkg::CFG_W'(taps);
		@(posedge clk);
		cfg_index <= mcf_pkg::REG_MODE;
		cfg_data  <= {5'($urandom_range(0, 31)), md};
		@(posedge clk);
		cfg_we   <= 1'b0;
		ntaps    = taps & 'h7f;
		cur_mode = md;
	endtask

	task automatic test_reset_defaults();
		send_item(make_item(mcf_pkg::OP_FILTER, 0, 0, 32767, -32768));
		send_item(make_item(OP_NONE, 7, 63, -1, -1));
		send_item(make_item(mcf_pkg::OP_TAP, 0, 0, -32768, 32767));
		send_item(make_item(mcf_pkg::OP_FILTER, 7, 0, -32768, 32767));
		send_item(make_item(mcf_pkg::OP_FILTER, 7, 0, 32767, 0));
	endtask

	task automatic test_config_extremes();
		configure(0, MODE_RESERVED);
		send_item(make_item(mcf_pkg::OP_FILTER, 3, 0, -32768, -32768));
		configure(127, MODE_CPLX_SAMPLES);
		send_item(make_item(mcf_pkg::OP_TAP, 0, 63, 32767, -32768));
		send_item(make_item(mcf_pkg::OP_TAP, 0, 1, 16384, 1));
		send_item(make_item(mcf_pkg::OP_FILTER, 5, 0, 32767, 32767));
		send_item(make_item(mcf_pkg::OP_FILTER, 5, 0, -32768, -32768));
		send_item(make_item(mcf_pkg::OP_FILTER, 5, 0, -1, 1));
		send_item(make_item(mcf_pkg::OP_FILTER, 5, 0, 0, -32768));
		send_item(make_item(mcf_pkg::OP_CLEAR, 5, 0, 0, 0));
		send_item(make_item(mcf_pkg::OP_FILTER, 5, 0, 1, -1));
		configure(64, mcf_pkg::MODE_REAL);
		send_item(make_item(mcf_pkg::OP_FILTER, 2, 0, -32768, 32767));
		send_item(make_item(OP_NONE, 0, 0, 0, 0));
		configure(2, mcf_pkg::MODE_CPLX_TAPS);
		send_item(make_item(mcf_pkg::OP_FILTER, 1, 0, 32767, -32768));
		send_item(make_item(mcf_pkg::OP_FILTER, 1, 0, -32768, 32767));
	endtask

	// hold the result side off while the sender keeps offering items
	task automatic test_output_holdoff();
		mcf_pkg::sample_t item;
		configure(3, MODE_CPLX_SAMPLES);
		send_pct = 0;
		stall_pct   <= 0;
		holds_asked <= holds_asked + 1;
		repeat (40) begin
			item    = random_item(mcf_pkg::CHANNELS - 1);
			item.op = mcf_pkg::OP_FILTER;
			send_item(item);
		end
	endtask

	task automatic run_phase(input int taps, input logic [mcf_pkg::MODE_W-1:0] md,
		input int sp, input int rp, input int n, input int ch_max);
		configure(taps, md);
		send_pct = sp;
		stall_pct <= rp;
		repeat (n) send_item(random_item(ch_max));
	endtask

	task automatic test_random();
		send_pct = 0;
		for (int k = 0; k < mcf_pkg::MAX_TAPS; k++)
			send_item(make_item(mcf_pkg::OP_TAP, $urandom_range(0, 7), k, pick_value(),
				pick_value()));
		run_phase(4,   mcf_pkg::MODE_REAL,      0,  0,  150, 7);
		run_phase(8,   MODE_CPLX_SAMPLES,       69, 0,  150, 7);
		run_phase(3,   mcf_pkg::MODE_CPLX_TAPS, 0,  69, 150, 7);
		run_phase(16,  MODE_RESERVED,           6,  6,  150, 3);
		run_phase(64,  mcf_pkg::MODE_CPLX_TAPS, 0,  0,  120, 1);
		run_phase(127, mcf_pkg::MODE_REAL,      6,  6,  40,  0);
		run_phase(0,   mcf_pkg::MODE_CPLX_TAPS, 69, 0,  100, 7);
		run_phase(33,  MODE_CPLX_SAMPLES,       0,  0,  100, 1);
		run_phase(7,   mcf_pkg::MODE_CPLX_TAPS, 6,  6,  200, 7);
		run_phase(2,   mcf_pkg::MODE_REAL,      0,  69, 150, 7);
		run_phase(12,  MODE_CPLX_SAMPLES,       69, 0,  150, 7);
	endtask

	always @(posedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken  <= holds_asked;
			hold_left    <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= $urandom_range(0, 99) < stall_pct;
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		mcf_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, result);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_re", want.out_re, result.out_re);
				check_field("out_im", want.out_im, result.out_im);
				check_field("out_channel", want.out_channel, result.out_channel);
				check_field("saturated", want.saturated, result.saturated);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		reset_filter_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_output_holdoff();
		test_random();
		settle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
